[rtl/length_prefixed_record_ring_assert.svh]
`ifndef LENGTH_PREFIXED_RECORD_RING_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_RING_ASSERT_SVH

// expr must hold in the same cycle as cond
`define LPRR_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lprr: same-cycle check failed");

// expr must hold in the cycle after cond
`define LPRR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lprr: next-cycle check failed");

`endif

[rtl/lprr_pkg.sv]
package lprr_pkg;

   localparam int RING_BYTES_DEF = 1024;
   localparam int MAX_RECORD_DEF = 64;
   localparam int SPARE_GAP_DEF  = 1;
   localparam int HEADER_BYTES   = 4;
   localparam int MIN_RING       = 16;
   localparam int RESET_RING     = 1024;

   localparam int SIZE_REG_W = 11;
   localparam int LEN_W      = 7;
   localparam int SPACE_W    = 11;
   // wide enough for any ring size the parameter range allows
   localparam int CMD_ADDR_W = 16;
   localparam int CMD_FREE_W = 17;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      FN_PUSH_START = 2'd0,
      FN_PUSH_BYTE  = 2'd1,
      FN_POP        = 2'd2,
      FN_PEEK       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NOTE = 2'd0,
      OP_HDR  = 2'd1,
      OP_BYTE = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef struct packed {
      func_type         func;
      logic [LEN_W-1:0] record_length;
      logic [7:0]       data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         out_byte;
      logic               out_last;
      logic [LEN_W-1:0]   out_length;
      logic [SPACE_W-1:0] space_left;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      status_type            status;
      logic [SPACE_W-1:0]    space;
      logic [CMD_ADDR_W-1:0] addr;
      logic [7:0]            data;
      logic                  pop;
      logic [CMD_FREE_W-1:0] free;
   } cmd_type;

   typedef struct packed {
      logic                  valid;
      logic [CMD_ADDR_W-1:0] addr;
      logic [LEN_W-1:0]      len;
   } done_type;

endpackage

[rtl/lprr_front.sv]
module lprr_front import lprr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   parameter int MAX_RECORD = MAX_RECORD_DEF,
   parameter int SPARE_GAP  = SPARE_GAP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  req_type                           req_data,
   output logic                              busy,
   input  logic                              cfg_write,
   input  logic [SIZE_REG_W-1:0]             cfg_data,
   input  done_type                          done,
   input  logic                              q_full,
   output logic                              q_push,
   output cmd_type                           q_cmd,
   output logic [$clog2(RING_BYTES+1)-1:0]   ring_size_eff,
   output logic                              pop_wait
);

   localparam int PTR_W    = $clog2(RING_BYTES);
   localparam int SIZE_W   = $clog2(RING_BYTES + 1);
   localparam int WIDE_W   = SIZE_W + 8;
   localparam int RESERVE  = SPARE_GAP + HEADER_BYTES;
   localparam int SIZE_RST = (RING_BYTES < RESET_RING) ? RING_BYTES : RESET_RING;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [PTR_W-1:0]  back_ff, back_in;
   logic [PTR_W-1:0]  write_ff, write_in;
   logic [LEN_W-1:0]  pending_ff, pending_in;
   logic [LEN_W:0]    rec_ff, rec_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic              wait_ff, wait_in;

   logic              accept;
   logic [SIZE_W-1:0] size_req;
   logic [WIDE_W-1:0] size_w, free_w, space_now, commit_free;
   logic [WIDE_W-1:0] hdr_sum, wr_sum;
   logic [PTR_W-1:0]  hdr_end, write_nxt;
   logic              reject;

   function automatic logic [WIDE_W-1:0] space_of(input logic [WIDE_W-1:0] f);
      space_of = (f > WIDE_W'(RESERVE)) ? f - WIDE_W'(RESERVE) : '0;
   endfunction

   assign accept        = start && !busy;
   assign busy          = wait_ff || q_full;
   assign pop_wait      = wait_ff;
   assign ring_size_eff = size_ff;

   always_comb begin
      if (32'(cfg_data) < MIN_RING) begin
         size_req = SIZE_W'(MIN_RING);
      end else if (32'(cfg_data) > RING_BYTES) begin
         size_req = SIZE_W'(RING_BYTES);
      end else begin
         size_req = SIZE_W'(cfg_data);
      end
   end

   always_comb begin
      size_w      = WIDE_W'(size_ff);
      free_w      = WIDE_W'(free_ff);
      space_now   = space_of(free_w);
      commit_free = free_w - WIDE_W'(rec_ff);
      hdr_sum     = WIDE_W'(back_ff) + WIDE_W'(HEADER_BYTES);
      if (hdr_sum >= size_w) begin
         hdr_sum = hdr_sum - size_w;
      end
      hdr_end = PTR_W'(hdr_sum);
      wr_sum  = WIDE_W'(write_ff) + WIDE_W'(1);
      if (wr_sum >= size_w) begin
         wr_sum = '0;
      end
      write_nxt = PTR_W'(wr_sum);
      reject = (req_data.record_length == '0)
            || (32'(req_data.record_length) > MAX_RECORD)
            || (WIDE_W'(req_data.record_length) > space_now);
   end

   always_comb begin
      size_in    = size_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      write_in   = write_ff;
      pending_in = pending_ff;
      rec_in     = rec_ff;
      free_in    = free_ff;
      wait_in    = wait_ff;
      q_push     = 1'b0;
      q_cmd      = '0;
      q_cmd.op   = OP_NOTE;
      q_cmd.status = ST_OK;
      q_cmd.space  = SPACE_W'(space_now);

      if (done.valid) begin
         front_in = PTR_W'(done.addr);
         free_in  = SIZE_W'(free_w + WIDE_W'(done.len) + WIDE_W'(HEADER_BYTES));
         wait_in  = 1'b0;
      end

      if (accept) begin
         q_push = 1'b1;
         case (req_data.func)
            FN_PUSH_START: begin
               pending_in = '0;
               if (reject) begin
                  q_cmd.status = ST_REJECT;
               end else begin
                  q_cmd.op   = OP_HDR;
                  q_cmd.addr = CMD_ADDR_W'(back_ff);
                  q_cmd.data = 8'(req_data.record_length);
                  write_in   = hdr_end;
                  pending_in = req_data.record_length;
                  rec_in     = (LEN_W + 1)'(req_data.record_length)
                             + (LEN_W + 1)'(HEADER_BYTES);
               end
            end
            FN_PUSH_BYTE: begin
               if (pending_ff == '0) begin
                  q_cmd.status = ST_REJECT;
               end else begin
                  q_cmd.op   = OP_BYTE;
                  q_cmd.addr = CMD_ADDR_W'(write_ff);
                  q_cmd.data = req_data.data_byte;
                  write_in   = write_nxt;
                  pending_in = pending_ff - LEN_W'(1);
                  // last payload byte: commit the record
                  if (pending_ff == LEN_W'(1)) begin
                     back_in     = write_nxt;
                     free_in     = SIZE_W'(commit_free);
                     q_cmd.space = SPACE_W'(space_of(commit_free));
                  end
               end
            end
            FN_POP, FN_PEEK: begin
               if (front_ff == back_ff) begin
                  q_cmd.status = ST_EMPTY;
               end else begin
                  q_cmd.op   = OP_READ;
                  q_cmd.addr = CMD_ADDR_W'(front_ff);
                  q_cmd.pop  = (req_data.func == FN_POP);
                  q_cmd.free = CMD_FREE_W'(free_ff);
                  // hold off further requests until the new front is known
                  if (req_data.func == FN_POP) begin
                     wait_in = 1'b1;
                  end
               end
            end
            default: begin
               q_cmd.status = ST_REJECT;
            end
         endcase
      end

      if (cfg_write) begin
         size_in    = size_req;
         front_in   = '0;
         back_in    = '0;
         write_in   = '0;
         pending_in = '0;
         free_in    = size_req;
         wait_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SIZE_W'(SIZE_RST);
         front_ff   <= '0;
         back_ff    <= '0;
         write_ff   <= '0;
         pending_ff <= '0;
         free_ff    <= SIZE_W'(SIZE_RST);
         wait_ff    <= 1'b0;
      end else begin
         size_ff    <= size_in;
         front_ff   <= front_in;
         back_ff    <= back_in;
         write_ff   <= write_in;
         pending_ff <= pending_in;
         free_ff    <= free_in;
         wait_ff    <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

[rtl/lprr_queue.sv]
module lprr_queue import lprr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head  = slot_ff[rd_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/lprr_back.sv]
module lprr_back import lprr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   parameter int MAX_RECORD = MAX_RECORD_DEF,
   parameter int SPARE_GAP  = SPARE_GAP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(RING_BYTES+1)-1:0]   ring_size_eff,
   input  logic                              q_empty,
   input  cmd_type                           q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   output rsp_type                           rsp_data,
   output done_type                          done,
   output logic                              idle
);

   localparam int PTR_W   = $clog2(RING_BYTES);
   localparam int WIDE_W  = $clog2(RING_BYTES + 1) + 8;
   localparam int RESERVE = SPARE_GAP + HEADER_BYTES;
   localparam int HCNT_W  = $clog2(HEADER_BYTES);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_HDR    = 4'b0010,
      S_RDHDR  = 4'b0100,
      S_RDDATA = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [HCNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]  out_cnt_ff, out_cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        b0_ff, b0_in;
   logic              hinz_ff, hinz_in;
   logic              pop_ff, pop_in;
   logic [WIDE_W-1:0] freeh_ff, freeh_in;
   logic [SPACE_W-1:0] space_ff, space_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   done_type          done_ff, done_in;
   logic [7:0]        rd_q_ff;

   logic [7:0]        mem [RING_BYTES];
   logic              we;
   logic [PTR_W-1:0]  wa, ra, head_addr, head_nxt, addr_nxt;
   logic [7:0]        wd;
   logic [WIDE_W-1:0] size_w, head_sum, addr_sum, rd_sum;
   logic [LEN_W-1:0]  len_final;
   logic              hi_nz;

   function automatic logic [WIDE_W-1:0] space_of(input logic [WIDE_W-1:0] f);
      space_of = (f > WIDE_W'(RESERVE)) ? f - WIDE_W'(RESERVE) : '0;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign done      = done_ff;
   assign idle      = (state_ff == S_IDLE);

   always_comb begin
      size_w    = WIDE_W'(ring_size_eff);
      head_addr = PTR_W'(q_head.addr);
      head_sum  = WIDE_W'(head_addr) + WIDE_W'(1);
      if (head_sum >= size_w) begin
         head_sum = '0;
      end
      head_nxt = PTR_W'(head_sum);
      addr_sum = WIDE_W'(addr_ff) + WIDE_W'(1);
      if (addr_sum >= size_w) begin
         addr_sum = '0;
      end
      addr_nxt = PTR_W'(addr_sum);

      // clamp the stored length into 1..MAX_RECORD
      hi_nz = hinz_ff || (rd_q_ff != '0);
      if (hi_nz) begin
         len_final = LEN_W'(MAX_RECORD);
      end else if (b0_ff == '0) begin
         len_final = LEN_W'(1);
      end else if (32'(b0_ff) > MAX_RECORD) begin
         len_final = LEN_W'(MAX_RECORD);
      end else begin
         len_final = LEN_W'(b0_ff);
      end
      rd_sum = freeh_ff + (pop_ff ? WIDE_W'(len_final) : '0);
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      out_cnt_in   = out_cnt_ff;
      len_in       = len_ff;
      b0_in        = b0_ff;
      hinz_in      = hinz_ff;
      pop_in       = pop_ff;
      freeh_in     = freeh_ff;
      space_in     = space_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      wa           = addr_ff;
      wd           = '0;
      ra           = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      done_in      = '0;

      case (state_ff)
         S_IDLE: begin
            ra = head_addr;
            if (!q_empty) begin
               q_pop = 1'b1;
               rsp_in.status     = q_head.status;
               rsp_in.out_last   = 1'b1;
               rsp_in.space_left = q_head.space;
               case (q_head.op)
                  OP_NOTE: begin
                     rsp_valid_in = 1'b1;
                  end
                  OP_BYTE: begin
                     rsp_valid_in = 1'b1;
                     we = 1'b1;
                     wa = head_addr;
                     wd = q_head.data;
                  end
                  OP_HDR: begin
                     rsp_valid_in = 1'b1;
                     we       = 1'b1;
                     wa       = head_addr;
                     wd       = q_head.data;
                     addr_in  = head_nxt;
                     cnt_in   = HCNT_W'(1);
                     state_in = S_HDR;
                  end
                  OP_READ: begin
                     addr_in  = head_nxt;
                     cnt_in   = '0;
                     pop_in   = q_head.pop;
                     hinz_in  = 1'b0;
                     freeh_in = WIDE_W'(q_head.free)
                              + (q_head.pop ? WIDE_W'(HEADER_BYTES) : '0);
                     state_in = S_RDHDR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_HDR: begin
            // upper header bytes are zero
            we      = 1'b1;
            wa      = addr_ff;
            wd      = '0;
            addr_in = addr_nxt;
            cnt_in  = cnt_ff + HCNT_W'(1);
            if (cnt_ff == HCNT_W'(HEADER_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_RDHDR: begin
            addr_in = addr_nxt;
            cnt_in  = cnt_ff + HCNT_W'(1);
            if (cnt_ff == '0) begin
               b0_in = rd_q_ff;
            end else if (cnt_ff == HCNT_W'(HEADER_BYTES - 1)) begin
               len_in     = len_final;
               space_in   = SPACE_W'(space_of(rd_sum));
               out_cnt_in = '0;
               state_in   = S_RDDATA;
            end else begin
               hinz_in = hinz_ff || (rd_q_ff != '0);
            end
         end
         S_RDDATA: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = ST_OK;
            rsp_in.out_byte   = rd_q_ff;
            rsp_in.out_length = len_ff;
            rsp_in.space_left = space_ff;
            if (out_cnt_ff == len_ff - LEN_W'(1)) begin
               rsp_in.out_last = 1'b1;
               state_in        = S_IDLE;
               if (pop_ff) begin
                  done_in.valid = 1'b1;
                  done_in.addr  = CMD_ADDR_W'(addr_ff);
                  done_in.len   = len_ff;
               end
            end else begin
               addr_in    = addr_nxt;
               out_cnt_in = out_cnt_ff + LEN_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cnt_ff     <= cnt_in;
      out_cnt_ff <= out_cnt_in;
      len_ff     <= len_in;
      b0_ff      <= b0_in;
      hinz_ff    <= hinz_in;
      pop_ff     <= pop_in;
      freeh_ff   <= freeh_in;
      space_ff   <= space_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_q_ff <= mem[ra];
   end

endmodule

[rtl/length_prefixed_record_ring.sv]
// Push start, payload byte, stray byte and empty read: one result, registered by the back end
// once the command has left the queue, when the back end is idle. A push start then holds the
// back end in its header state to write the upper header bytes; a payload byte does not hold it.
// Pop/peek: the back end reads the header bytes, then gives one payload byte a cycle; a pop
// keeps busy high through the cycle of its last result, a peek does not. A 4-entry command
// queue parts the sides; busy rises when it is full. Results cannot be stalled.
// Synchronous reset empties the ring, sizes it to min(1024, RING_BYTES); RAM is not cleared.
module length_prefixed_record_ring import lprr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   parameter int MAX_RECORD = MAX_RECORD_DEF,
   parameter int SPARE_GAP  = SPARE_GAP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_type               req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_REG_W-1:0] csr_data
);

`include "length_prefixed_record_ring_assert.svh"

   localparam int SIZE_W = $clog2(RING_BYTES + 1);

   logic              cfg_write;
   done_type          done;
   logic              q_full, q_empty, q_push, q_pop;
   cmd_type           q_cmd, q_head;
   logic [SIZE_W-1:0] ring_size_eff;
   logic              pop_wait;
   logic              back_idle;

   // hold off a size write while a request is offered or earlier work is still in flight
   assign csr_ready = !pop_wait && q_empty && back_idle && !start;
   assign cfg_write = csr_valid && csr_ready;

   lprr_front #(
      .RING_BYTES(RING_BYTES),
      .MAX_RECORD(MAX_RECORD),
      .SPARE_GAP (SPARE_GAP)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .busy         (busy),
      .cfg_write    (cfg_write),
      .cfg_data     (csr_data),
      .done         (done),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (q_cmd),
      .ring_size_eff(ring_size_eff),
      .pop_wait     (pop_wait)
   );

   lprr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   lprr_back #(
      .RING_BYTES(RING_BYTES),
      .MAX_RECORD(MAX_RECORD),
      .SPARE_GAP (SPARE_GAP)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .ring_size_eff(ring_size_eff),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .done         (done),
      .idle         (back_idle)
   );

   `LPRR_ASSERT_IMP(a_queue_no_overflow, clock, reset, q_push, !q_full)
   `LPRR_ASSERT_IMP(a_done_on_last, clock, reset, done.valid, rsp_valid && rsp_data.out_last)
   `LPRR_ASSERT_IMP(a_done_only_when_waiting, clock, reset, done.valid, pop_wait)
   `LPRR_ASSERT_NEXT(a_done_releases_front, clock, reset, done.valid, !pop_wait)

endmodule

[tb/tb_length_prefixed_record_ring.sv]
module tb_length_prefixed_record_ring;
   import lprr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   req_type               req_data = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [SIZE_REG_W-1:0] csr_data = '0;

   length_prefixed_record_ring DUT (
      .clock,
      .reset,
      .start,
      .req_data,
      .busy,
      .rsp_valid,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_requests[$];
   rsp_type expected_results[$];

   logic req_taken = 1'b0;
   int   gap_left = 0;
   int   burst_left = 0;
   int   mismatch_count = 0;
   int   results_checked = 0;
   int   requests_taken = 0;
   int   size_writes = 0;
   int   func_count[4] = '{0, 0, 0, 0};

   // ring predictor state
   logic [7:0]  ring_image[RING_BYTES_DEF];
   int unsigned size_setting;
   int unsigned front_ptr;
   int unsigned back_ptr;
   int unsigned fill_ptr;
   int unsigned bytes_due;

   function automatic int unsigned ring_span();
      if (size_setting < MIN_RING) return MIN_RING;
      if (size_setting > RING_BYTES_DEF) return RING_BYTES_DEF;
      return size_setting;
   endfunction

   function automatic int unsigned free_space();
      int unsigned span, used, room;
      span = ring_span();
      used = (back_ptr + span - front_ptr) % span;
      room = span - used;
      if (room <= SPARE_GAP_DEF + HEADER_BYTES) return 0;
      return room - (SPARE_GAP_DEF + HEADER_BYTES);
   endfunction

   function automatic void set_ring_size(int unsigned value);
      size_setting = value;
      front_ptr = 0;
      back_ptr = 0;
      fill_ptr = 0;
      bytes_due = 0;
   endfunction

   // space_left is taken after the request has updated the pointers
   function automatic void expect_result(status_type st, logic [7:0] b, logic last,
                                         int unsigned len);
      rsp_type want;
      want.status = st;
      want.out_byte = b;
      want.out_last = last;
      want.out_length = len[LEN_W-1:0];
      want.space_left = free_space();
      expected_results.push_back(want);
   endfunction

   function automatic void predict_ring_step(req_type r);
      logic [7:0]  payload[MAX_RECORD_DEF];
      logic [31:0] header;
      int unsigned len, p, span;
      span = ring_span();
      case (r.func)
         FN_PUSH_START: begin
            bytes_due = 0;
            fill_ptr = back_ptr;
            if (r.record_length == 0 || r.record_length > MAX_RECORD_DEF ||
                r.record_length > free_space()) begin
               expect_result(ST_REJECT, 8'h00, 1'b1, 0);
            end else begin
               for (int i = 0; i < HEADER_BYTES; i++)
                  ring_image[(back_ptr + i) % span] = (i == 0) ? {1'b0, r.record_length} : 8'h00;
               fill_ptr = (back_ptr + HEADER_BYTES) % span;
               bytes_due = r.record_length;
               expect_result(ST_OK, 8'h00, 1'b1, 0);
            end
         end
         FN_PUSH_BYTE: begin
            if (bytes_due == 0) begin
               expect_result(ST_REJECT, 8'h00, 1'b1, 0);
            end else begin
               ring_image[fill_ptr] = r.data_byte;
               fill_ptr = (fill_ptr + 1) % span;
               bytes_due--;
               // commit the record on its last byte
               if (bytes_due == 0) back_ptr = fill_ptr;
               expect_result(ST_OK, 8'h00, 1'b1, 0);
            end
         end
         default: begin
            if (front_ptr == back_ptr) begin
               expect_result(ST_EMPTY, 8'h00, 1'b1, 0);
            end else begin
               for (int i = 0; i < 4; i++)
                  header[8*i +: 8] = ring_image[(front_ptr + i) % span];
               len = header;
               if (len == 0) len = 1;
               if (len > MAX_RECORD_DEF) len = MAX_RECORD_DEF;
               p = (front_ptr + HEADER_BYTES) % span;
               for (int i = 0; i < len; i++) begin
                  payload[i] = ring_image[p];
                  p = (p + 1) % span;
               end
               if (r.func == FN_POP) front_ptr = p;
               for (int i = 0; i < len; i++)
                  expect_result(ST_OK, payload[i], (i + 1 == len), len);
            end
         end
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      if (mismatch_count < 40) $display("[%0t] ERROR: %s", $realtime, what);
      mismatch_count++;
   endtask

   // driver: present queued requests, hold each until accepted, then idle a drawn gap
   always @(negedge clock) begin
      req_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left = gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            start <= 1'b1;
            req_data <= next_req;
            if (burst_left != 0) begin
               burst_left = burst_left - 1;
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 18);
               if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(4, 30);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results first, then predict for the request accepted at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf("result with nothing expected: %p", rsp_data));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                          results_checked, rsp_data.status, want.status));
               if (rsp_data.out_byte !== want.out_byte)
                  flag_mismatch($sformatf("result %0d out_byte %0h, expected %0h",
                                          results_checked, rsp_data.out_byte, want.out_byte));
               if (rsp_data.out_last !== want.out_last)
                  flag_mismatch($sformatf("result %0d out_last %0b, expected %0b",
                                          results_checked, rsp_data.out_last, want.out_last));
               if (rsp_data.out_length !== want.out_length)
                  flag_mismatch($sformatf("result %0d out_length %0d, expected %0d",
                                          results_checked, rsp_data.out_length,
                                          want.out_length));
               if (rsp_data.space_left !== want.space_left)
                  flag_mismatch($sformatf("result %0d space_left %0d, expected %0d",
                                          results_checked, rsp_data.space_left,
                                          want.space_left));
               results_checked++;
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            predict_ring_step(req_data);
            func_count[int'(req_data.func)]++;
            requests_taken++;
         end
      end
   end

   task automatic add_item(func_type f, int len = 0, int b = 0);
      req_type r;
      r.func = f;
      r.record_length = (f == FN_PUSH_START) ? len[LEN_W-1:0]
                                             : LEN_W'($urandom_range(0, 127));
      r.data_byte = (f == FN_PUSH_BYTE) ? b[7:0] : 8'($urandom_range(0, 255));
      pending_requests.push_back(r);
   endtask

   task automatic add_record(int len);
      add_item(FN_PUSH_START, len);
      for (int i = 0; i < len; i++) add_item(FN_PUSH_BYTE, 0, $urandom_range(0, 255));
   endtask

   task automatic random_traffic(int count);
      int added, pick, len, cut;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, MAX_RECORD_DEF)
                                               : $urandom_range(1, 8);
            add_record(len);
            added += len + 1;
         end else if (pick < 70) begin
            add_item(FN_POP);
            added++;
         end else if (pick < 80) begin
            add_item(FN_PEEK);
            added++;
         end else if (pick < 85) begin
            add_item(FN_PUSH_BYTE, 0, $urandom_range(0, 255));
            added++;
         end else if (pick < 90) begin
            len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_RECORD_DEF + 1, 127);
            add_item(FN_PUSH_START, len);
            added++;
         end else if (pick < 95) begin
            // partial push, left open for whatever comes next
            len = $urandom_range(2, 8);
            cut = $urandom_range(0, len - 1);
            add_item(FN_PUSH_START, len);
            for (int i = 0; i < cut; i++) add_item(FN_PUSH_BYTE, 0, $urandom_range(0, 255));
            added += cut + 1;
         end else begin
            // read in the middle of an open push
            len = $urandom_range(2, 8);
            cut = $urandom_range(1, len - 1);
            add_item(FN_PUSH_START, len);
            for (int i = 0; i < len; i++) begin
               if (i == cut) begin
                  if ($urandom_range(0, 1) == 0) add_item(FN_POP);
                  else add_item(FN_PEEK);
               end
               add_item(FN_PUSH_BYTE, 0, $urandom_range(0, 255));
            end
            added += len + 2;
         end
      end
   endtask

   // hold until every queued request is taken and every result has come, then settle
   task automatic wait_idle();
      while (pending_requests.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_ring_size(int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value[SIZE_REG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      set_ring_size(value[SIZE_REG_W-1:0]);
      size_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned ring_sizes[7];
      ring_sizes = '{5, 2047, 23, 0, 100, 16, RING_BYTES_DEF};
      ring_sizes[5] = $urandom_range(MIN_RING, RING_BYTES_DEF);
      set_ring_size(RESET_RING);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty reads, stray byte, bad lengths, abandoned push, read during an open push
      add_item(FN_POP);
      add_item(FN_PEEK);
      add_item(FN_PUSH_BYTE, 0, 8'h55);
      add_item(FN_PUSH_START, 0);
      add_item(FN_PUSH_START, 127);
      add_item(FN_PUSH_START, 2);
      add_item(FN_PUSH_BYTE, 0, 8'hFF);
      add_item(FN_PUSH_START, 1);
      add_item(FN_PUSH_BYTE, 0, 8'h00);
      add_item(FN_PUSH_START, 2);
      add_item(FN_PUSH_BYTE, 0, 8'hAA);
      add_item(FN_PEEK);
      add_item(FN_POP);
      add_item(FN_PUSH_BYTE, 0, 8'h01);
      add_item(FN_POP);
      add_item(FN_POP);
      wait_idle();

      // smallest ring: fill to no free space, reject on space
      write_ring_size(MIN_RING);
      add_item(FN_PUSH_START, 12);
      add_record(3);
      add_item(FN_PUSH_START, 5);
      add_record(4);
      add_item(FN_PUSH_START, 1);
      add_item(FN_POP);
      add_item(FN_POP);
      wait_idle();
      random_traffic(16);
      wait_idle();

      foreach (ring_sizes[k]) begin
         write_ring_size(ring_sizes[k]);
         if (ring_sizes[k] == RING_BYTES_DEF) begin
            add_record(MAX_RECORD_DEF);
            add_item(FN_PEEK);
            add_item(FN_POP);
         end
         random_traffic(12);
         wait_idle();
      end

      $display("Covered %0d requests: %0d push starts, %0d payload bytes, %0d pops, %0d peeks",
               requests_taken, func_count[FN_PUSH_START], func_count[FN_PUSH_BYTE],
               func_count[FN_POP], func_count[FN_PEEK]);
      $display("%0d results checked over %0d ring size writes, including out-of-range sizes",
               results_checked, size_writes);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #3000000;
      $display("Timed out with %0d results still expected", expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/lprr_pkg.sv
rtl/lprr_front.sv
rtl/lprr_queue.sv
rtl/lprr_back.sv
rtl/length_prefixed_record_ring.sv
tb/tb_length_prefixed_record_ring.sv
